// ===== rtl/mulord_pkg.sv =====
package mulord_pkg;

  // Sequencer states of the order search
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_TEST,
    ST_MUL,
    ST_FINISH
  } state_e;

endpackage

// ===== rtl/multiplicative_order_mod_n_top.sv =====
// Sequence: one multiplier pass reduces the residue, then one pass per power step;
//   a unit of order k takes k-1 power steps, a non-unit up to m-1.
// Throughput: one transaction at a time, data dependent; the serial multiplier sets it.
// Input is taken again as soon as the sequencer is idle, even with a result pending.
// Reset (rst_ni low, async) clears the sequencer and output valid and sets modulus to 2.
module multiplicative_order_mod_n_top #(
  parameter int WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // modulus register write
  input  logic                            cfg_we_i,
  input  logic [WIDTH-1:0]                cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [((WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,  // [WIDTH-1:0] residue
  // result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [((WIDTH+7)/8)*8-1:0]      m_axis_tdata_o,  // [WIDTH-1:0] order_value
  output logic                            m_axis_tuser_o   // [0] non_unit
);

  localparam int DataW = ((WIDTH + 7) / 8) * 8;

  mulord_pkg::state_e state_q, state_d;

  logic [WIDTH-1:0] mod_q;      // configured modulus m
  logic [WIDTH-1:0] a_q, a_d;   // residue reduced mod m
  logic [WIDTH-1:0] p_q, p_d;   // running power a^k mod m
  logic [WIDTH-1:0] k_q, k_d;   // exponent of p_q
  logic [WIDTH-1:0] ord_q, ord_d;
  logic             nu_q, nu_d;

  logic             out_vld_q, out_vld_d;
  logic [WIDTH-1:0] out_ord_q, out_ord_d;
  logic             out_nu_q, out_nu_d;

  logic             mm_start;
  logic [WIDTH-1:0] mm_x;
  logic [WIDTH-1:0] mm_y;
  logic             mm_done;
  logic [WIDTH-1:0] mm_r;

  logic             in_txn;

  assign s_axis_tready_o = (state_q == mulord_pkg::ST_IDLE);
  assign in_txn          = s_axis_tvalid_i && s_axis_tready_o;

  // Operand select: reduction is 1 * residue mod m, search steps are p * a mod m
  assign mm_x = (state_q == mulord_pkg::ST_IDLE) ? WIDTH'(1) : p_q;
  assign mm_y = (state_q == mulord_pkg::ST_IDLE) ? s_axis_tdata_i[WIDTH-1:0] : a_q;

  mulord_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .m_i     (mod_q),
    .done_o  (mm_done),
    .r_o     (mm_r)
  );

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    p_d       = p_q;
    k_d       = k_q;
    ord_d     = ord_q;
    nu_d      = nu_q;
    out_vld_d = out_vld_q;
    out_ord_d = out_ord_q;
    out_nu_d  = out_nu_q;
    mm_start  = 1'b0;

    // result consumed downstream
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      mulord_pkg::ST_IDLE: begin
        if (in_txn) begin
          if (mod_q < WIDTH'(2)) begin
            // degenerate modulus: everything reduces to zero
            ord_d   = '0;
            nu_d    = 1'b1;
            state_d = mulord_pkg::ST_FINISH;
          end else begin
            mm_start = 1'b1;
            state_d  = mulord_pkg::ST_REDUCE;
          end
        end
      end
      mulord_pkg::ST_REDUCE: begin
        if (mm_done) begin
          a_d     = mm_r;
          p_d     = mm_r;
          k_d     = WIDTH'(1);
          state_d = mulord_pkg::ST_TEST;
        end
      end
      mulord_pkg::ST_TEST: begin
        if (p_q == WIDTH'(1)) begin
          ord_d   = k_q;
          nu_d    = 1'b0;
          state_d = mulord_pkg::ST_FINISH;
        end else if (p_q == '0 || k_q == mod_q) begin
          // zero power sticks at zero; a unit returns to one before count m
          ord_d   = '0;
          nu_d    = 1'b1;
          state_d = mulord_pkg::ST_FINISH;
        end else begin
          mm_start = 1'b1;
          state_d  = mulord_pkg::ST_MUL;
        end
      end
      mulord_pkg::ST_MUL: begin
        if (mm_done) begin
          p_d     = mm_r;
          k_d     = k_q + 1'b1;
          state_d = mulord_pkg::ST_TEST;
        end
      end
      mulord_pkg::ST_FINISH: begin
        // wait for a free output register
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_ord_d = ord_q;
          out_nu_d  = nu_q;
          state_d   = mulord_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mulord_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mulord_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      mod_q     <= WIDTH'(2);
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    p_q       <= p_d;
    k_q       <= k_d;
    ord_q     <= ord_d;
    nu_q      <= nu_d;
    out_ord_q <= out_ord_d;
    out_nu_q  <= out_nu_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = DataW'(out_ord_q);
  assign m_axis_tuser_o  = out_nu_q;

endmodule

// ===== rtl/mulord_mulmod.sv =====
// Bit-serial modular multiplier: r = x * y mod m, MSB of y first.
// Needs x < m. One step per cycle; done pulses once the last step is in r.
module mulord_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] r_o
);

  localparam int CntW = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [WIDTH-1:0] m_q, m_d;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;
  logic [WIDTH+1:0] red;

  // sum = 2r + bit*x < 3m, fold back with one of two subtracts
  always_comb begin
    m1  = {2'b00, m_q};
    m2  = {1'b0, m_q, 1'b0};
    sum = {1'b0, r_q, 1'b0} + (y_q[WIDTH-1] ? {2'b00, x_q} : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    x_d    = x_q;
    y_d    = y_q;
    m_d    = m_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WIDTH - 1);
      r_d    = '0;
      x_d    = x_i;
      y_d    = y_i;
      m_d    = m_i;
    end else if (busy_q) begin
      r_d   = red[WIDTH-1:0];
      y_d   = {y_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
    y_q <= y_d;
    m_q <= m_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule
